>>> rtl/core/kmr_pkg.sv
// Package for the key matrix report engine: constants, key code table,
// queue entry types. No dependencies.
`default_nettype none

package kmr_pkg;

    localparam int KEY_BITS          = 30;    // 6 rows x 5 columns, bit row*5+col
    localparam int REPORT_SLOTS_DEF  = 6;
    localparam int READ_CAP          = 6;     // a read never emits more bytes
    localparam int QUEUE_DEPTH       = 2;
    localparam int CODE_W            = 8;

    localparam logic [7:0] CMD_SLEEP     = 8'hAB;
    localparam logic [7:0] CMD_PING      = 8'h69;
    localparam logic [7:0] PING_REPLY_RST = 8'h69;

    localparam logic [1:0] ACT_SCAN = 2'd0;
    localparam logic [1:0] ACT_CMD  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Key codes in matrix bit order (row-major).
    localparam logic [7:0] KEY_CODE_TABLE [KEY_BITS] = '{
        8'h14, 8'h1A, 8'h08, 8'h15, 8'h17,
        8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13,
        8'h04, 8'h16, 8'h07, 8'h09, 8'h0A,
        8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h2A,
        8'h1D, 8'h1B, 8'h06, 8'h19, 8'h2C,
        8'h00, 8'h05, 8'h11, 8'h10, 8'h28
    };

    typedef enum logic [2:0] {
        KIND_SCAN,
        KIND_READ,
        KIND_SLEEP,
        KIND_PING,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  found;   // scan saw at least one pressed key
    } entry_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/key_matrix_report_engine_top.sv
// Top level of the key matrix report engine: front classifier, entry queue,
// back end with report state. Depends on kmr_pkg, kmr_front, kmr_queue, kmr_back.
//
// Use:
//   s_axis carries one transaction per item: tuser = action (0 scan, 1 command
//   byte, 2 report read), tdata = key matrix bits and command byte.
//   m_axis returns the results: one status beat per scan or command, and six
//   report bytes per read with tlast on the sixth.
//   cfg_wr_en/cfg_wr_data write the ping reply byte; write it only while idle.
// Timing:
//   An accepted transaction is written into the queue; the back end pops it
//   and loads its first result into the output register. Scans and commands
//   are taken by the back end at one transaction per cycle while m_axis_tready
//   is high. A read holds the back end until its report bytes are all sent;
//   the front keeps queueing meanwhile.
// Reset:
//   Report slots clear, the interrupt level is released (high), the report
//   state machine starts in its start-up phase, the ping reply is 0x69.
// Stall:
//   A low m_axis_tready holds the output register; the back end stops, the
//   two-entry queue fills, then s_axis_tready drops. Nothing is lost.
`default_nettype none

module key_matrix_report_engine_top #(
    parameter int REPORT_SLOTS = kmr_pkg::REPORT_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [29:0] key_matrix, [37:30] command_byte, pad
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [8] irq_line_n,
                                             // [9] sleep_request, pad
    output logic             m_axis_tlast,   // last_byte
    output logic [0:0]       m_axis_tuser    // [0] reply_valid
);

    localparam int KB      = kmr_pkg::KEY_BITS;
    localparam int CODES_W = REPORT_SLOTS * kmr_pkg::CODE_W;
    localparam int ENTRY_W = $bits(kmr_pkg::entry_ctl_t) + CODES_W + REPORT_SLOTS;

    kmr_pkg::entry_ctl_t        front_ctl, back_ctl;
    logic [CODES_W-1:0]         front_codes, back_codes;
    logic [REPORT_SLOTS-1:0]    front_mask, back_mask;
    logic [ENTRY_W-1:0]         push_data, pop_data;
    logic                       pop_valid, pop_ready;
    logic [7:0]                 data_byte;
    logic                       irq_line_n, sleep_request, reply_valid;

    // Classify the incoming transaction.
    kmr_front #(
        .REPORT_SLOTS(REPORT_SLOTS)
    ) u_front (
        .action       (s_axis_tuser),
        .key_matrix   (s_axis_tdata[KB-1:0]),
        .command_byte (s_axis_tdata[KB+7:KB]),
        .ctl          (front_ctl),
        .codes        (front_codes),
        .slot_mask    (front_mask)
    );

    assign push_data = {front_mask, front_codes, front_ctl};

    // Decouple front from back so each side stalls on its own.
    kmr_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {back_mask, back_codes, back_ctl} = pop_data;

    // Carry out the entry: update report state, sequence read bytes.
    kmr_back #(
        .REPORT_SLOTS(REPORT_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .ctl           (back_ctl),
        .codes         (back_codes),
        .slot_mask     (back_mask),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .data_byte     (data_byte),
        .last_byte     (m_axis_tlast),
        .irq_line_n    (irq_line_n),
        .sleep_request (sleep_request),
        .reply_valid   (reply_valid)
    );

    assign m_axis_tdata = {6'b0, sleep_request, irq_line_n, data_byte};
    assign m_axis_tuser = reply_valid;

endmodule

`default_nettype wire

>>> rtl/core/kmr_front.sv
// Front end: classify an incoming transaction and build its queue entry.
// Depends on kmr_pkg.
`default_nettype none

module kmr_front #(
    parameter int REPORT_SLOTS = kmr_pkg::REPORT_SLOTS_DEF
) (
    input  wire logic [1:0]                        action,
    input  wire logic [kmr_pkg::KEY_BITS-1:0]      key_matrix,
    input  wire logic [7:0]                        command_byte,
    output kmr_pkg::entry_ctl_t                    ctl,
    output logic [REPORT_SLOTS*kmr_pkg::CODE_W-1:0] codes,
    output logic [REPORT_SLOTS-1:0]                slot_mask
);

    localparam int KB     = kmr_pkg::KEY_BITS;
    localparam int CW     = kmr_pkg::CODE_W;
    localparam int RANK_W = $clog2(KB + 1);

    logic [RANK_W-1:0] rank [KB];
    logic [RANK_W-1:0] total;
    logic [KB-1:0]     lower_mask [KB];

    // Rank of each key = number of pressed keys before it in scan order.
    always_comb
    begin
        total = RANK_W'($countones(key_matrix));
        for (int b = 0; b < KB; b++)
        begin
            lower_mask[b] = (KB'(1) << b) - KB'(1);
            rank[b]       = RANK_W'($countones(key_matrix & lower_mask[b]));
        end
    end

    // Slot s takes the code of the pressed key whose rank is s; drop the rest.
    always_comb
    begin
        codes     = '0;
        slot_mask = '0;
        for (int s = 0; s < REPORT_SLOTS; s++)
        begin
            slot_mask[s] = (total > RANK_W'(s));
            for (int b = 0; b < KB; b++)
            begin
                if (key_matrix[b] && (rank[b] == RANK_W'(s)))
                begin
                    codes[s*CW +: CW] = codes[s*CW +: CW] | kmr_pkg::KEY_CODE_TABLE[b];
                end
            end
        end
    end

    always_comb
    begin
        ctl.found = (total != '0);
        unique case (action)
            kmr_pkg::ACT_SCAN: ctl.kind = kmr_pkg::KIND_SCAN;
            kmr_pkg::ACT_READ: ctl.kind = kmr_pkg::KIND_READ;
            kmr_pkg::ACT_CMD:
            begin
                if (command_byte == kmr_pkg::CMD_SLEEP)
                begin
                    ctl.kind = kmr_pkg::KIND_SLEEP;
                end
                else if (command_byte == kmr_pkg::CMD_PING)
                begin
                    ctl.kind = kmr_pkg::KIND_PING;
                end
                else
                begin
                    ctl.kind = kmr_pkg::KIND_NOP;
                end
            end
            default: ctl.kind = kmr_pkg::KIND_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/kmr_queue.sv
// Short queue between front and back end, valid/ready on both sides.
// Depends on kmr_pkg.
`default_nettype none

module kmr_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = kmr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

>>> rtl/core/kmr_back.sv
// Back end: report slots, report state machine, read-out sequencer and
// output register. Depends on kmr_pkg.
`default_nettype none

module kmr_back #(
    parameter int REPORT_SLOTS = kmr_pkg::REPORT_SLOTS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [7:0]                             cfg_wr_data,
    input  wire logic                                   pop_valid,
    output logic                                        pop_ready,
    input  wire kmr_pkg::entry_ctl_t                    ctl,
    input  wire logic [REPORT_SLOTS*kmr_pkg::CODE_W-1:0] codes,
    input  wire logic [REPORT_SLOTS-1:0]                slot_mask,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [7:0]                                  data_byte,
    output logic                                        last_byte,
    output logic                                        irq_line_n,
    output logic                                        sleep_request,
    output logic                                        reply_valid
);

    localparam int CW     = kmr_pkg::CODE_W;
    localparam int READ_N = (REPORT_SLOTS < kmr_pkg::READ_CAP) ? REPORT_SLOTS
                                                               : kmr_pkg::READ_CAP;
    localparam int SLOT_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(READ_N - 1);

    typedef enum logic [1:0] {
        PH_STARTUP,
        PH_ACTIVE,
        PH_RELEASE
    } phase_t;

    logic [CW-1:0]     slots_reg [REPORT_SLOTS];
    logic [CW-1:0]     slots_next [REPORT_SLOTS];
    phase_t            phase_reg, phase_next;
    logic              irq_reg, irq_next;
    logic              reading_reg, reading_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [7:0]        ping_reg, ping_next;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              irq_out_reg, irq_out_next;
    logic              sleep_reg, sleep_next;
    logic              reply_reg, reply_next;

    logic              can_issue;
    logic              pop;

    assign can_issue = !m_valid_reg || m_ready;
    assign pop_ready = can_issue && !reading_reg;
    assign pop       = pop_valid && pop_ready;

    assign m_valid       = m_valid_reg;
    assign data_byte     = byte_reg;
    assign last_byte     = last_reg;
    assign irq_line_n    = irq_out_reg;
    assign sleep_request = sleep_reg;
    assign reply_valid   = reply_reg;

    always_comb
    begin
        slots_next   = slots_reg;
        phase_next   = phase_reg;
        irq_next     = irq_reg;
        reading_next = reading_reg;
        idx_next     = idx_reg;
        ping_next    = cfg_wr_en ? cfg_wr_data : ping_reg;
        m_valid_next = m_valid_reg && !m_ready;
        byte_next    = byte_reg;
        last_next    = last_reg;
        irq_out_next = irq_out_reg;
        sleep_next   = sleep_reg;
        reply_next   = reply_reg;

        if (can_issue && reading_reg)
        begin
            // Emit the next report byte and clear its slot.
            m_valid_next       = 1'b1;
            byte_next          = slots_reg[idx_reg];
            slots_next[idx_reg] = '0;
            last_next          = (idx_reg == LAST_IDX);
            sleep_next         = 1'b0;
            reply_next         = 1'b0;
            irq_out_next       = irq_reg;
            if (idx_reg == LAST_IDX)
            begin
                reading_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + SLOT_W'(1);
            end
        end
        else if (pop)
        begin
            m_valid_next = 1'b1;
            byte_next    = '0;
            last_next    = 1'b0;
            sleep_next   = 1'b0;
            reply_next   = 1'b0;
            unique case (ctl.kind)
                kmr_pkg::KIND_SCAN:
                begin
                    if (phase_reg == PH_ACTIVE || (phase_reg == PH_RELEASE && ctl.found))
                    begin
                        if (ctl.found)
                        begin
                            for (int s = 0; s < REPORT_SLOTS; s++)
                            begin
                                if (slot_mask[s])
                                begin
                                    slots_next[s] = codes[s*CW +: CW];
                                end
                            end
                            irq_next   = 1'b0;
                            phase_next = PH_RELEASE;
                        end
                    end
                    else
                    begin
                        // Start-up or release: send a null report.
                        for (int s = 0; s < REPORT_SLOTS; s++)
                        begin
                            slots_next[s] = '0;
                        end
                        irq_next   = 1'b0;
                        phase_next = PH_ACTIVE;
                    end
                end
                kmr_pkg::KIND_READ:
                begin
                    irq_next      = 1'b1;
                    byte_next     = slots_reg[0];
                    slots_next[0] = '0;
                    last_next     = (READ_N == 1);
                    reading_next  = (READ_N > 1);
                    idx_next      = SLOT_W'(1);
                end
                kmr_pkg::KIND_SLEEP: sleep_next = 1'b1;
                kmr_pkg::KIND_PING:
                begin
                    byte_next  = ping_reg;
                    reply_next = 1'b1;
                end
                default: ;
            endcase
            irq_out_next = irq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < REPORT_SLOTS; s++)
            begin
                slots_reg[s] <= '0;
            end
            phase_reg   <= PH_STARTUP;
            irq_reg     <= 1'b1;
            reading_reg <= 1'b0;
            idx_reg     <= '0;
            ping_reg    <= kmr_pkg::PING_REPLY_RST;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            slots_reg   <= slots_next;
            phase_reg   <= phase_next;
            irq_reg     <= irq_next;
            reading_reg <= reading_next;
            idx_reg     <= idx_next;
            ping_reg    <= ping_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        irq_out_reg <= irq_out_next;
        sleep_reg   <= sleep_next;
        reply_reg   <= reply_next;
    end

    a_read_idx: assert property (@(posedge clk) disable iff (!rst_n)
        reading_reg |-> (idx_reg != '0 && idx_reg <= LAST_IDX))
        else $error("read index out of range");

    a_read_release: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ctl.kind == kmr_pkg::KIND_READ) |=> (irq_reg && m_valid_reg))
        else $error("read did not release the interrupt line");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && last_reg) |-> (!sleep_reg && !reply_reg && irq_out_reg))
        else $error("final read byte carries command flags");

endmodule

`default_nettype wire
